>>> rtl/tps_pkg.sv
// Package with the shared types and constants of the topological sort core.
`timescale 1ns / 1ps

package tps_pkg;

	// Fixed widths of the stream fields and of the configuration register.
	localparam int VERTEX_W  = 6;
	localparam int VCOUNT_W  = 6;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 8;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_POP,
		ST_FETCH,
		ST_HEAD,
		ST_EDGE,
		ST_DEG,
		ST_STATUS
	} tps_state_t;

endpackage

>>> rtl/topological_sort_core.sv
// Top level of the topological sort core: edge loading and Kahn's sort sequencer.
`timescale 1ns / 1ps

// The core loads a directed graph one edge per input transfer and, on the transfer
// marked with tlast, runs Kahn's topological sort and streams out the vertices in
// order followed by one status transfer (tuser high, tlast high). For an edge
// transfer the list head and in-degree memories are read in the accept cycle and
// written back in the next while s_tready is low; a dropped or empty transfer
// is not written back. The sort first scans the in-degree memory, then for each
// emitted vertex reads the ready queue and the list head, and for each edge visited
// reads the edge memory and does an in-degree read-modify-write; at the end it finds
// the ready queue empty and sends the status transfer. The output side can stall
// both vertex and status transfers. The per-vertex tables are cleared at the end of
// each sort by their valid bits, so the core needs no clearing pass after reset.
module topological_sort_core
	import tps_pkg::*;
#(
	parameter int MAX_VERTICES = 63,
	parameter int MAX_EDGES    = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration: vertex_count.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [VCOUNT_W-1:0]  cfg_data,
	// Edge input.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [5:0] edge_source, [11:6] edge_target, rest zero
	input  logic                 s_tuser,   // edge_valid
	input  logic                 s_tlast,   // last_edge
	// Sorted vertices and status.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [5:0] vertex, [6] cycle_found, [7] edges_dropped
	output logic                 m_tuser,   // is_status
	output logic                 m_tlast    // last
);

	localparam int VD = MAX_VERTICES + 1;
	localparam int VA = $clog2(VD);
	localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int LW = $clog2(MAX_EDGES + 1);

	tps_state_t state_q, state_d;

	// Configuration and loading registers.
	logic [VCOUNT_W-1:0] vcount_q;
	logic [VA-1:0]       src_q, dst_q;
	logic                last_q;
	logic [LW-1:0]       stored_q;
	logic                drop_q;
	logic [VD-1:0]       head_vld_q, deg_vld_q;

	// Sort registers.
	logic [VA-1:0]       n_q;
	logic [VA:0]         scan_q;
	logic                chk_s1;
	logic [VA-1:0]       chk_v_s1;
	logic [VA-1:0]       rd_ptr_q, wr_ptr_q, emit_q;
	logic [VA-1:0]       w_q;
	logic [LW-1:0]       link_q;

	// Output register.
	logic                m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;
	logic                m_status_q;

	// Memory ports.
	logic                head_we, deg_we, el_we, fifo_we;
	logic [VA-1:0]       head_waddr, head_raddr, deg_waddr, deg_raddr, fifo_raddr;
	logic [LW-1:0]       head_wdata, deg_wdata, head_q, deg_q;
	logic [EA-1:0]       el_waddr, el_raddr;
	logic [LW+VA-1:0]    el_wdata, el_q;
	logic [VA-1:0]       fifo_q;
	logic [VA-1:0]       head_a_s1, deg_a_s1;

	// Control strobes from the sequencer.
	logic                in_xfer, edge_ok, take_fields, set_drop, store_edge, start_sort;
	logic                scan_issue, scan_clear, enq, emit_vertex, emit_status;
	logic                link_load;
	logic [VA-1:0]       enq_v;

	logic [VERTEX_W-1:0] in_src, in_dst;
	logic [VA-1:0]       n_cur;
	logic                out_free;
	logic [LW-1:0]       head_rd, deg_rd;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign m_tuser   = m_status_q;
	assign m_tlast   = m_status_q;

	assign in_xfer  = s_tvalid && s_tready;
	assign in_src   = s_tdata[VERTEX_W-1:0];
	assign in_dst   = s_tdata[2*VERTEX_W-1:VERTEX_W];
	assign out_free = !m_valid_q || m_tready;

	// Active vertex count, capped at MAX_VERTICES.
	assign n_cur = (int'(vcount_q) > MAX_VERTICES) ? VA'(MAX_VERTICES) : VA'(vcount_q);

	// An edge marked valid is stored when both ends are in range (1 to the vertex count) and the edge table has room.
	assign edge_ok = s_tuser && (in_src != '0) && (in_dst != '0)
		&& (int'(in_src) <= int'(n_cur)) && (int'(in_dst) <= int'(n_cur))
		&& (int'(stored_q) < MAX_EDGES);

	// Entries never written since the last clear read as zero.
	assign head_rd = head_vld_q[head_a_s1] ? head_q : '0;
	assign deg_rd  = deg_vld_q[deg_a_s1] ? deg_q : '0;

	// The ready queue is always read at its read pointer.
	assign fifo_raddr = rd_ptr_q;

	// Sequencer: next state, memory ports and strobes.
	always_comb begin
		state_d     = state_q;
		head_we     = 1'b0;
		head_waddr  = src_q;
		head_wdata  = LW'(stored_q + 1'b1);
		head_raddr  = VA'(in_src);
		deg_we      = 1'b0;
		deg_waddr   = dst_q;
		deg_wdata   = LW'(deg_rd + 1'b1);
		deg_raddr   = VA'(in_dst);
		el_we       = 1'b0;
		el_waddr    = EA'(stored_q);
		el_wdata    = {head_rd, dst_q};
		el_raddr    = EA'(link_q - 1'b1);
		fifo_we     = 1'b0;
		enq_v       = chk_v_s1;
		take_fields = 1'b0;
		set_drop    = 1'b0;
		store_edge  = 1'b0;
		start_sort  = 1'b0;
		scan_issue  = 1'b0;
		scan_clear  = 1'b0;
		enq         = 1'b0;
		emit_vertex = 1'b0;
		emit_status = 1'b0;
		link_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					take_fields = 1'b1;
					if (edge_ok) begin
						state_d = ST_LOAD;
					end else begin
						set_drop = s_tuser;
						if (s_tlast) begin
							start_sort = 1'b1;
							state_d    = ST_SCAN;
						end
					end
				end
			end
			ST_LOAD: begin
				// Write back the list head, the in-degree and the new edge entry.
				head_we    = 1'b1;
				deg_we     = 1'b1;
				el_we      = 1'b1;
				store_edge = 1'b1;
				if (last_q) begin
					start_sort = 1'b1;
					state_d    = ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				// Check the in-degree read last cycle and issue the next read.
				if (chk_s1 && (deg_rd == '0)) begin
					fifo_we = 1'b1;
					enq     = 1'b1;
				end
				deg_raddr = VA'(scan_q);
				if (scan_q <= {1'b0, n_q}) begin
					scan_issue = 1'b1;
				end else begin
					scan_clear = 1'b1;
					if (!chk_s1) begin
						state_d = ST_POP;
					end
				end
			end
			ST_POP: begin
				if (rd_ptr_q != wr_ptr_q) begin
					state_d = ST_FETCH;
				end else begin
					state_d = ST_STATUS;
				end
			end
			ST_FETCH: begin
				head_raddr = fifo_q;
				if (out_free) begin
					emit_vertex = 1'b1;
					state_d     = ST_HEAD;
				end
			end
			ST_HEAD: begin
				el_raddr = EA'(head_rd - 1'b1);
				if (head_rd == '0) begin
					state_d = ST_POP;
				end else begin
					state_d = ST_EDGE;
				end
			end
			ST_EDGE: begin
				deg_raddr = el_q[VA-1:0];
				link_load = 1'b1;
				state_d   = ST_DEG;
			end
			ST_DEG: begin
				// Decrement the successor's in-degree and queue it when it reaches zero.
				deg_waddr = w_q;
				deg_wdata = LW'(deg_rd - 1'b1);
				enq_v     = w_q;
				if (deg_rd != '0) begin
					deg_we = 1'b1;
					if (deg_rd == LW'(1)) begin
						fifo_we = 1'b1;
						enq     = 1'b1;
					end
				end
				if (link_q == '0) begin
					state_d = ST_POP;
				end else begin
					state_d = ST_EDGE;
				end
			end
			ST_STATUS: begin
				if (out_free) begin
					emit_status = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: counters, pointers, flags and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q   <= '0;
			stored_q   <= '0;
			drop_q     <= 1'b0;
			head_vld_q <= '0;
			deg_vld_q  <= '0;
			chk_s1     <= 1'b0;
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			emit_q     <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				vcount_q <= cfg_data;
			end
			if (set_drop) begin
				drop_q <= 1'b1;
			end
			if (store_edge) begin
				stored_q           <= LW'(stored_q + 1'b1);
				head_vld_q[src_q]  <= 1'b1;
				deg_vld_q[dst_q]   <= 1'b1;
			end
			if (scan_issue) begin
				chk_s1 <= 1'b1;
			end else if (scan_clear) begin
				chk_s1 <= 1'b0;
			end
			if (enq) begin
				wr_ptr_q <= VA'(wr_ptr_q + 1'b1);
			end
			if (emit_vertex) begin
				rd_ptr_q <= VA'(rd_ptr_q + 1'b1);
				emit_q   <= VA'(emit_q + 1'b1);
			end
			if (emit_vertex || emit_status) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			// The status transfer closes the run and clears the graph.
			if (emit_status) begin
				stored_q   <= '0;
				drop_q     <= 1'b0;
				head_vld_q <= '0;
				deg_vld_q  <= '0;
				rd_ptr_q   <= '0;
				wr_ptr_q   <= '0;
				emit_q     <= '0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		head_a_s1 <= head_raddr;
		deg_a_s1  <= deg_raddr;
		if (take_fields) begin
			src_q  <= VA'(in_src);
			dst_q  <= VA'(in_dst);
			last_q <= s_tlast;
		end
		if (start_sort) begin
			n_q    <= n_cur;
			scan_q <= (VA + 1)'(1);
		end
		if (scan_issue) begin
			scan_q   <= (VA + 1)'(scan_q + 1'b1);
			chk_v_s1 <= VA'(scan_q);
		end
		if (link_load) begin
			w_q    <= el_q[VA-1:0];
			link_q <= el_q[LW+VA-1:VA];
		end
		if (emit_vertex) begin
			m_data_q   <= {2'b00, VERTEX_W'(fifo_q)};
			m_status_q <= 1'b0;
		end
		if (emit_status) begin
			m_data_q   <= {drop_q, (emit_q < n_q), VERTEX_W'(0)};
			m_status_q <= 1'b1;
		end
	end

	// Per-vertex list heads.
	tps_ram #(.WIDTH(LW), .DEPTH(VD)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (head_raddr),
		.rdata (head_q)
	);

	// Per-vertex in-degrees.
	tps_ram #(.WIDTH(LW), .DEPTH(VD)) u_deg_ram (
		.clk   (clk),
		.we    (deg_we),
		.waddr (deg_waddr),
		.wdata (deg_wdata),
		.raddr (deg_raddr),
		.rdata (deg_q)
	);

	// Edge table: next-edge link in the upper bits, target vertex in the lower bits.
	tps_ram #(.WIDTH(LW + VA), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (el_we),
		.waddr (el_waddr),
		.wdata (el_wdata),
		.raddr (el_raddr),
		.rdata (el_q)
	);

	// Queue of vertices whose in-degree has reached zero.
	tps_ram #(.WIDTH(VA), .DEPTH(VD)) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (wr_ptr_q),
		.wdata (enq_v),
		.raddr (fifo_raddr),
		.rdata (fifo_q)
	);

endmodule

>>> rtl/tps_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module tps_ram
	import tps_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
